>>> rtl/core/lpr_pkg.sv
// Shared constants, state codes and control types for the LRU page replacement unit.
package lpr_pkg;

    localparam int FRAMES_DEF    = 4;
    localparam int PAGE_BITS_DEF = 20;
    localparam int RANK_BITS     = 6;
    // A frame entering the set counts as rank FRAMES, which needs one more bit.
    localparam int OLD_W         = RANK_BITS + 1;
    localparam int FRAME_FIELD_W = 6;
    localparam int FAULT_W       = 32;
    localparam int TUSER_W       = 2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // Broadcast from the top level to every cell.
    typedef struct packed {
        logic capture;   // lookup result is latched into the cells
        logic update;    // selected frame moves to most recent
        logic hit;       // some valid frame matches the incoming page
        logic full;      // every frame holds a page
    } ctrl_t;

endpackage

>>> rtl/core/lpr_cell.sv
// One page frame of the replacement chain: page, valid mark, recency rank.
module lpr_cell #(
    parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
    parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
    parameter int IDX_W     = 2,
    parameter int IDX       = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lpr_pkg::ctrl_t             ctrl,
    input  logic [PAGE_BITS-1:0]       req_page,
    input  logic [PAGE_BITS-1:0]       wr_page,
    input  logic [lpr_pkg::OLD_W-1:0]  old_rank,
    input  logic                       prev_valid,
    output logic                       valid,
    output logic                       match,
    output logic                       sel,
    input  logic [lpr_pkg::OLD_W-1:0]  bus_rank_in,
    input  logic [IDX_W-1:0]           bus_idx_in,
    input  logic [PAGE_BITS-1:0]       bus_page_in,
    output logic [lpr_pkg::OLD_W-1:0]  bus_rank_out,
    output logic [IDX_W-1:0]           bus_idx_out,
    output logic [PAGE_BITS-1:0]       bus_page_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
    localparam logic [lpr_pkg::RANK_BITS-1:0] LRU_RANK = lpr_pkg::RANK_BITS'(FRAMES - 1);
    localparam logic [lpr_pkg::OLD_W-1:0] ENTRY_RANK = lpr_pkg::OLD_W'(FRAMES);

    logic [PAGE_BITS-1:0]          page_reg;
    logic                          valid_reg, valid_next;
    logic [lpr_pkg::RANK_BITS-1:0] rank_reg, rank_next;
    logic                          sel_reg, sel_next;
    logic                          empty_first;
    logic                          victim;
    logic [lpr_pkg::OLD_W-1:0]     my_old;

    // Frames fill from the lowest index, so the first empty one follows a valid one.
    assign empty_first = !valid_reg && prev_valid;
    assign victim      = valid_reg && (rank_reg == LRU_RANK);
    assign match       = valid_reg && (page_reg == req_page);
    assign my_old      = valid_reg ? {1'b0, rank_reg} : ENTRY_RANK;

    always_comb
    begin
        sel_next = sel_reg;
        if (ctrl.capture)
        begin
            sel_next = ctrl.hit ? match : (ctrl.full ? victim : empty_first);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (ctrl.update)
        begin
            if (sel_reg)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
            end
            else if (valid_reg && ({1'b0, rank_reg} < old_rank))
            begin
                rank_next = rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            sel_reg   <= sel_next;
        end
    end

    // On a hit the page written equals the one held.
    always_ff @(posedge clk)
    begin
        if (ctrl.update && sel_reg)
        begin
            page_reg <= wr_page;
        end
    end

    assign valid = valid_reg;
    assign sel   = sel_reg;

    // Merge this frame's data into the chain bus when it is the selected one.
    assign bus_rank_out = bus_rank_in | (sel_reg ? my_old : '0);
    assign bus_idx_out  = bus_idx_in  | (sel_reg ? MY_IDX : '0);
    assign bus_page_out = bus_page_in | (sel_reg ? page_reg : '0);

endmodule

>>> rtl/core/lru_page_replacement_unit.sv
// Top level of the LRU page replacement unit: cell chain, sequencer and result register.
//
//  channel | dir | fields (tdata / tuser, lowest bit first)
//  --------+-----+------------------------------------------------------------------
//  s_      | in  | tdata: page
//  m_      | out | tdata: frame, evicted_page, fault_count; tuser: hit, evicted_valid
//
// A request is taken in the idle state: the accepting edge compares the page against every
// cell at once and latches the chosen frame in its cell; the update state walks the chain
// bus for the chosen frame's rank, index and old page, ages the younger frames and
// loads the result register. The chain bus through the FRAMES cells sets the update
// state's path. Reset empties every frame and clears the fault count; no clearing pass.
// A result waiting on m_tready holds the update cycle; the unit then takes no request.
module lru_page_replacement_unit #(
    parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
    localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int S_W      = ((PAGE_BITS + 7) / 8) * 8,
    localparam int O_RAW    = lpr_pkg::FRAME_FIELD_W + PAGE_BITS + lpr_pkg::FAULT_W,
    localparam int M_W      = ((O_RAW + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [S_W-1:0]              s_tdata,   // page
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [M_W-1:0]              m_tdata,   // frame, evicted_page, fault_count
    output logic [lpr_pkg::TUSER_W-1:0] m_tuser    // hit, evicted_valid
);

    localparam logic [lpr_pkg::FAULT_W-1:0] FAULT_MAX = '1;

    lpr_pkg::state_t state_reg, state_next;
    lpr_pkg::ctrl_t  ctrl;

    logic capture;
    logic upd;

    logic [PAGE_BITS-1:0]         page_reg;
    logic                         hit_reg;
    logic                         evict_reg;
    logic [lpr_pkg::FAULT_W-1:0]  faults_reg, faults_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [M_W-1:0]               m_tdata_reg;
    logic [lpr_pkg::TUSER_W-1:0]  m_tuser_reg;

    logic [FRAMES-1:0] valid_v;
    logic [FRAMES-1:0] match_v;
    logic [FRAMES-1:0] sel_v;
    logic [FRAMES:0]   prev_v;

    logic [lpr_pkg::OLD_W-1:0] bus_rank [FRAMES+1];
    logic [IDX_W-1:0]          bus_idx  [FRAMES+1];
    logic [PAGE_BITS-1:0]      bus_page [FRAMES+1];

    logic match_any;
    logic full;

    assign match_any = |match_v;
    assign full      = valid_v[FRAMES-1];
    assign capture   = s_tvalid && s_tready;

    assign ctrl.capture = capture;
    assign ctrl.update  = upd;
    assign ctrl.hit     = match_any;
    assign ctrl.full    = full;

    // Chain: cell 0 sees a valid left neighbor so it is the first empty frame after reset.
    assign prev_v[0]   = 1'b1;
    assign bus_rank[0] = '0;
    assign bus_idx[0]  = '0;
    assign bus_page[0] = '0;

    for (genvar i = 0; i < FRAMES; i++)
    begin : g_cell
        lpr_cell #(
            .PAGE_BITS (PAGE_BITS),
            .FRAMES    (FRAMES),
            .IDX_W     (IDX_W),
            .IDX       (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .req_page     (s_tdata[PAGE_BITS-1:0]),
            .wr_page      (page_reg),
            .old_rank     (bus_rank[FRAMES]),
            .prev_valid   (prev_v[i]),
            .valid        (valid_v[i]),
            .match        (match_v[i]),
            .sel          (sel_v[i]),
            .bus_rank_in  (bus_rank[i]),
            .bus_idx_in   (bus_idx[i]),
            .bus_page_in  (bus_page[i]),
            .bus_rank_out (bus_rank[i+1]),
            .bus_idx_out  (bus_idx[i+1]),
            .bus_page_out (bus_page[i+1])
        );
        assign prev_v[i+1] = valid_v[i];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lpr_pkg::ST_IDLE:
            begin
                if (capture)
                begin
                    state_next = lpr_pkg::ST_UPDATE;
                end
            end
            lpr_pkg::ST_UPDATE:
            begin
                if (upd)
                begin
                    state_next = lpr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lpr_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: take a request only when idle, finish only into a free result slot.
    always_comb
    begin
        s_tready = 1'b0;
        upd      = 1'b0;
        unique case (state_reg)
            lpr_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            lpr_pkg::ST_UPDATE:
            begin
                upd = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
                upd      = 1'b0;
            end
        endcase
    end

    // Count the fault at lookup time; saturate at all ones.
    always_comb
    begin
        faults_next = faults_reg;
        if (capture && !match_any && (faults_reg != FAULT_MAX))
        begin
            faults_next = faults_reg + 1'b1;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (upd)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lpr_pkg::ST_IDLE;
            faults_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            faults_reg   <= faults_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold the request and its lookup outcome for the update cycle.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            page_reg  <= s_tdata[PAGE_BITS-1:0];
            hit_reg   <= match_any;
            evict_reg <= !match_any && full;
        end
    end

    // Load the result from the chain bus; the evicted page is zero unless a page left.
    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            m_tdata_reg <= M_W'({faults_reg,
                                 (evict_reg ? bus_page[FRAMES] : {PAGE_BITS{1'b0}}),
                                 lpr_pkg::FRAME_FIELD_W'(bus_idx[FRAMES])});
            m_tuser_reg <= {evict_reg, hit_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Exactly one frame is chosen whenever the update cycle runs.
    a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lpr_pkg::ST_UPDATE) |-> $onehot(sel_v))
        else $error("update cycle without exactly one selected frame");

    // A page sits in at most one valid frame.
    a_unique_page: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_v))
        else $error("page resident in more than one frame");

    // The fault count never goes backward.
    a_faults_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (faults_reg >= $past(faults_reg)))
        else $error("fault count decreased");

    // A finished update always returns the sequencer to idle with a result pending.
    a_upd_done: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> (state_reg == lpr_pkg::ST_IDLE) && m_tvalid_reg)
        else $error("update did not complete into the result register");

endmodule

>>> dv/lru_frame_checker.sv
// Checker for the LRU page replacement unit: tracks the frame set and compares every result.
module lru_frame_checker #(
    parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lpr_pkg::PAGE_BITS_DEF,
    parameter int S_W       = 24,
    parameter int M_W       = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [S_W-1:0]              s_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [M_W-1:0]              m_tdata,
    input  logic [lpr_pkg::TUSER_W-1:0] m_tuser,
    output int                          errors,
    output int                          pending,
    output int                          results,
    output int                          hits,
    output int                          evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIT_BIT   = 0;
    localparam int EVICT_BIT = 1;
    localparam int FRAME_W   = lpr_pkg::FRAME_FIELD_W;
    localparam int EV_LSB    = FRAME_W;
    localparam int FAULT_LSB = EV_LSB + PAGE_BITS;
    localparam int MAX_LINES = 40;
    localparam logic [lpr_pkg::FAULT_W-1:0] FAULT_MAX = '1;

    typedef struct packed {
        logic                        hit;
        logic [FRAME_W-1:0]          frame;
        logic                        ev_valid;
        logic [PAGE_BITS-1:0]        ev_page;
        logic [lpr_pkg::FAULT_W-1:0] fault_count;
    } placement_t;

    logic [PAGE_BITS-1:0]         page_held [FRAMES];
    logic                         held      [FRAMES];
    logic [lpr_pkg::RANK_BITS-1:0] age_rank [FRAMES];
    logic [lpr_pkg::FAULT_W-1:0]  fault_total;
    placement_t                   expected_placements [$];

    task automatic report_mismatch(input string field, input longint unsigned got_v,
                                   input longint unsigned want_v);
        errors++;
        if (errors <= MAX_LINES)
            $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h",
                     $time, results, field, got_v, want_v);
    endtask

    // Make frame f the most recent; valid frames younger than its old rank age by one.
    // An empty frame coming in counts as older than every valid one.
    function automatic void promote_frame(input int f);
        int old_rank;
        int j;
        old_rank = held[f] ? int'(age_rank[f]) : FRAMES;
        for (j = 0; j < FRAMES; j++)
            if (j != f && held[j] && int'(age_rank[j]) < old_rank)
                age_rank[j] = age_rank[j] + 1'b1;
        age_rank[f] = '0;
        held[f]     = 1'b1;
    endfunction

    function automatic placement_t resolve_request(input logic [S_W-1:0] word);
        logic [PAGE_BITS-1:0] page;
        placement_t           r;
        int                   f;
        int                   j;
        bit                   found;
        page  = word[PAGE_BITS-1:0];   // bits above the page field are dropped
        r     = '0;
        f     = 0;
        found = 1'b0;
        for (j = 0; j < FRAMES; j++)
            if (!found && held[j] && page_held[j] == page) begin
                f     = j;
                found = 1'b1;
            end
        r.hit = found;
        if (!found) begin
            if (fault_total != FAULT_MAX)
                fault_total = fault_total + 1'b1;
            for (j = 0; j < FRAMES; j++)
                if (!found && !held[j]) begin
                    f     = j;
                    found = 1'b1;
                end
            if (!found) begin
                // lowest-numbered frame among the oldest goes
                f = 0;
                for (j = 1; j < FRAMES; j++)
                    if (age_rank[j] > age_rank[f])
                        f = j;
                r.ev_valid = 1'b1;
                r.ev_page  = page_held[f];
            end
            promote_frame(f);
            page_held[f] = page;
        end
        else begin
            promote_frame(f);
        end
        r.frame       = FRAME_W'(f);
        r.fault_count = fault_total;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        placement_t want;
        placement_t got;
        if (!rst_n) begin
            for (int j = 0; j < FRAMES; j++)
            begin
                page_held[j] = '0;
                held[j]      = 1'b0;
                age_rank[j]  = '0;
            end
            fault_total = '0;
            expected_placements.delete();
            errors    = 0;
            pending   = 0;
            results   = 0;
            hits      = 0;
            evictions = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got.hit         = m_tuser[HIT_BIT];
                got.ev_valid    = m_tuser[EVICT_BIT];
                got.frame       = m_tdata[FRAME_W-1:0];
                got.ev_page     = m_tdata[EV_LSB +: PAGE_BITS];
                got.fault_count = m_tdata[FAULT_LSB +: lpr_pkg::FAULT_W];
                results++;
                if (expected_placements.size() == 0) begin
                    report_mismatch("unexpected result, none outstanding", 64'(got), 64'd0);
                end
                else begin
                    want = expected_placements.pop_front();
                    if (got.hit != want.hit)
                        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                    if (got.frame != want.frame)
                        report_mismatch("frame", 64'(got.frame), 64'(want.frame));
                    if (got.ev_valid != want.ev_valid)
                        report_mismatch("evicted_valid", 64'(got.ev_valid),
                                        64'(want.ev_valid));
                    if (got.ev_page != want.ev_page)
                        report_mismatch("evicted_page", 64'(got.ev_page),
                                        64'(want.ev_page));
                    if (got.fault_count != want.fault_count)
                        report_mismatch("fault_count", 64'(got.fault_count),
                                        64'(want.fault_count));
                    if (want.hit)
                        hits++;
                    if (want.ev_valid)
                        evictions++;
                end
            end
            if (s_tvalid && s_tready)
                expected_placements.push_back(resolve_request(s_tdata));
            pending = expected_placements.size();
        end
    end

endmodule

>>> dv/tb_lru_page_replacement_unit.sv
// Testbench top for the LRU page replacement unit: clock, reset, request stimulus and verdict.
module tb_lru_page_replacement_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES       = lpr_pkg::FRAMES_DEF;
    localparam int PAGE_BITS    = lpr_pkg::PAGE_BITS_DEF;
    localparam int S_W          = ((PAGE_BITS + 7) / 8) * 8;
    localparam int M_W          = ((lpr_pkg::FRAME_FIELD_W + PAGE_BITS + lpr_pkg::FAULT_W + 7)
                                   / 8) * 8;
    localparam int TOTAL_ITEMS  = 600;
    localparam int TAIL_ITEMS   = 80;       // final stretch runs with no idling
    localparam int DRAIN_CYCLES = 10;       // leave room for a stray result
    localparam int CYCLE_LIMIT  = 200000;

    logic                        clk;
    logic                        rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [S_W-1:0]              s_tdata;    // page
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [M_W-1:0]              m_tdata;    // frame, evicted_page, fault_count
    logic [lpr_pkg::TUSER_W-1:0] m_tuser;    // hit, evicted_valid

    int  errors;
    int  pending;
    int  results;
    int  hits;
    int  evictions;
    int  sent;
    int  directed_count;
    int  cycle_count;
    int  ready_left;
    bit  quiet_tail;

    lru_page_replacement_unit #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    lru_frame_checker #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .S_W       (S_W),
        .M_W       (M_W)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .errors    (errors),
        .pending   (pending),
        .results   (results),
        .hits      (hits),
        .evictions (evictions)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Hard stop: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: alternate ready and stall bursts, hold ready high in the tail.
    always @(posedge clk)
    begin
        if (quiet_tail)
            m_tready <= 1'b1;
        else if (ready_left > 0)
            ready_left <= ready_left - 1;
        else if (m_tready && $urandom_range(0, 2) == 0)
        begin
            m_tready   <= 1'b0;
            ready_left <= $urandom_range(1, 12);
        end
        else
        begin
            m_tready   <= 1'b1;
            ready_left <= $urandom_range(1, 24);
        end
    end

    // Offer one request; idle first now and then, then hold it until accepted.
    task automatic offer_page(input logic [S_W-1:0] word);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    // Pages lean toward both ends of the range so every bit toggles and extremes recur.
    function automatic logic [PAGE_BITS-1:0] draw_page();
        logic [PAGE_BITS-1:0] pg;
        case ($urandom_range(0, 3))
            0:       pg = PAGE_BITS'($urandom_range(0, 15));
            1:       pg = '1 - PAGE_BITS'($urandom_range(0, 15));
            default: pg = PAGE_BITS'($urandom);
        endcase
        return pg;
    endfunction

    initial
    begin : stimulus
        logic [PAGE_BITS-1:0] pool [FRAMES + 3];
        logic [S_W-1:0]       word;
        int                   pool_size;
        int                   burst_len;
        int                   pick;
        int                   k;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        quiet_tail  = 1'b0;
        sent        = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: fill the empty frames in order, hit, then evict the oldest.
        offer_page(S_W'(20'h00000));
        offer_page(S_W'(20'hFFFFF));
        offer_page(S_W'(20'h00000));
        offer_page(S_W'(20'h55555));
        offer_page(S_W'(20'hAAAAA));
        offer_page(S_W'(20'hFFFFF));
        offer_page(S_W'(20'h12345));
        offer_page(S_W'(20'h12345));
        offer_page(S_W'(20'h00001));
        // Bits above the page field set: the request must reduce to the low bits.
        offer_page({{(S_W - PAGE_BITS){1'b1}}, PAGE_BITS'(20'h55555)});
        offer_page({{(S_W - PAGE_BITS){1'b1}}, PAGE_BITS'(20'hFFFFF)});
        // One more page than frames, cycled: every request misses and evicts.
        for (k = 0; k < 10; k++)
            offer_page(S_W'(20'h00100 * ((k % (FRAMES + 1)) + 1)));
        directed_count = sent;

        // Random: mostly working sets a little larger or smaller than the frame count,
        // so hits, fills and evictions interleave; the rest is wide-range noise.
        // The fault count cannot reach saturation in a run of this length.
        while (sent < TOTAL_ITEMS)
        begin
            if (sent >= TOTAL_ITEMS - TAIL_ITEMS)
                quiet_tail <= 1'b1;
            if ($urandom_range(0, 4) == 0)
            begin
                word = S_W'($urandom);
                if ($urandom_range(0, 9) != 0)
                    word[S_W-1:PAGE_BITS] = '0;
                offer_page(word);
            end
            else
            begin
                pool_size = $urandom_range(FRAMES - 1, FRAMES + 3);
                for (k = 0; k < pool_size; k++)
                    pool[k] = draw_page();
                burst_len = $urandom_range(8, 30);
                pick      = 0;
                for (k = 0; k < burst_len; k++)
                begin
                    // sometimes repeat the last page to bias toward hits on the newest
                    if ($urandom_range(0, 3) != 0)
                        pick = $urandom_range(0, pool_size - 1);
                    offer_page(S_W'(pool[pick]));
                end
            end
        end
        s_tvalid <= 1'b0;
        quiet_tail <= 1'b1;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d page requests (%0d directed), checked %0d results:",
                 sent, directed_count, results);
        $display("%0d hits, %0d evictions. Mismatches found: %0d", hits, evictions, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
